FILE: hdl/image_header_size_sniffer_core_macros.svh
// Assertion macros used by the image header size sniffer checker.
`ifndef IMAGE_HEADER_SIZE_SNIFFER_CORE_MACROS_SVH
`define IMAGE_HEADER_SIZE_SNIFFER_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted
`define IHSS_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ihss assertion failed");

// Next-cycle implication, switched off while reset is asserted
`define IHSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ihss assertion failed");

// Next-cycle implication that also holds across reset
`define IHSS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ihss assertion failed");

`endif

FILE: hdl/ihss_pkg.sv
// Types and constants of the image header size sniffer.
package ihss_pkg;

    // Number of leading bytes kept for the GIF and PNG headers
    localparam int HDR_LEN   = 24;
    localparam int HDR_IDX_W = 5;
    // Frame header bytes kept: precision skipped, then height and width
    localparam int FRM_LEN   = 4;

    localparam logic [7:0] JPEG_MARK  = 8'hFF;
    localparam logic [7:0] JPEG_SOI   = 8'hD8;
    localparam logic [7:0] SOF0       = 8'hC0;
    localparam logic [7:0] SOF3       = 8'hC3;
    localparam logic [7:0] SOF9       = 8'hC9;
    localparam logic [7:0] SOF11      = 8'hCB;
    localparam logic [7:0] PNG_LEAD   = 8'h89;

    typedef enum logic [3:0] {
        PH_SIG,
        PH_HEADER,
        PH_MARK0,
        PH_MARK1,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_FRAME,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        FMT_NONE,
        FMT_JPEG,
        FMT_GIF,
        FMT_PNG
    } t_fmt;

    // One result item
    typedef struct packed {
        logic        found;
        t_fmt        fmt;
        logic [30:0] width;
        logic [30:0] height;
    } t_result;

    // Per-file parser state
    typedef struct packed {
        t_phase      phase;
        logic [15:0] skip;
        logic        is_sof;
        logic [7:0]  len_hi;
        logic        sent;
        t_result     verdict;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{
        phase:   PH_SIG,
        skip:    16'd0,
        is_sof:  1'b0,
        len_hi:  8'd0,
        sent:    1'b0,
        verdict: '{found: 1'b0, fmt: FMT_NONE, width: 31'd0, height: 31'd0}
    };

endpackage

FILE: hdl/ihss_byte_if.sv
// Byte stream channel: one file byte and its end-of-file mark per transfer.
interface ihss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

FILE: hdl/ihss_size_if.sv
// Result channel: format and pixel size of one file per transfer.
interface ihss_size_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  image_format;
    logic [30:0] image_width;
    logic [30:0] image_height;

    modport source (output valid, output found, output image_format,
                    output image_width, output image_height, input ready);
    modport sink   (input valid, input found, input image_format,
                    input image_width, input image_height, output ready);
endinterface

FILE: hdl/image_header_size_sniffer_core.sv
// Image header size sniffer: finds format and pixel size of JPEG, GIF and PNG files.
//
// Usage:
//   i_byte carries the file one byte per transfer, end_of_file set on the last
//   byte. Files follow one another on the same channel with no gap needed.
//   o_size gives exactly one transfer per file: found, image_format (0 none,
//   1 JPEG, 2 GIF, 3 PNG), image_width and image_height; a failure reports
//   found=0 with all other fields zero.
//   Throughput is one byte per cycle while no held result is stalled: a byte
//   goes from the input register through the parser logic into the result
//   register. A result is valid once the byte that settles it (the byte at
//   offset MIN_FILE_BYTES-1 at the earliest, or the final byte) has been
//   taken into the input register and the parser, working on that register,
//   has loaded the result register.
//   The result register lets the next byte be accepted while a result waits;
//   when the receiver stalls with a result held, i_byte.ready drops once the
//   input register is also full, and nothing is lost.
//   Reset clears the parser to the start of a file and empties both registers;
//   header bytes need no clearing as each is written before it is read.
module image_header_size_sniffer_core #(
    parameter int MIN_FILE_BYTES = 24,
    localparam int OFS_W = $clog2(MIN_FILE_BYTES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ihss_byte_if.sink          i_byte,
    ihss_size_if.source        o_size
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;

    // Parser state
    ihss_pkg::t_parse                    r_st;
    logic [OFS_W-1:0]                    r_ofs;
    logic [ihss_pkg::HDR_LEN-1:0][7:0]   r_hdr;
    logic [ihss_pkg::FRM_LEN-1:0][7:0]   r_frm;

    ihss_pkg::t_parse                    n_st;
    logic [OFS_W-1:0]                    n_ofs;
    logic [ihss_pkg::HDR_LEN-1:0][7:0]   n_hdr;
    logic [ihss_pkg::FRM_LEN-1:0][7:0]   n_frm;
    logic                                n_emit;
    ihss_pkg::t_result                   n_res;

    // Result register
    logic              r_out_valid;
    ihss_pkg::t_result r_out;

    logic w_advance;
    logic w_in_xfer;

    assign w_advance    = !r_out_valid || o_size.ready;
    assign i_byte.ready = !r_in_valid || w_advance;
    assign w_in_xfer    = i_byte.valid && i_byte.ready;

    // Input register, emptied whenever the parser takes its byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_byte.data_byte;
            r_in_eof  <= i_byte.end_of_file;
        end
    end

    ihss_step #(
        .MIN_FILE_BYTES (MIN_FILE_BYTES)
    ) u_step (
        .i_st   (r_st),
        .i_ofs  (r_ofs),
        .i_hdr  (r_hdr),
        .i_frm  (r_frm),
        .i_byte (r_in_byte),
        .i_eof  (r_in_eof),
        .o_st   (n_st),
        .o_ofs  (n_ofs),
        .o_hdr  (n_hdr),
        .o_frm  (n_frm),
        .o_emit (n_emit),
        .o_res  (n_res)
    );

    // Parser control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ihss_pkg::PARSE_CLEAR;
            r_ofs <= '0;
        end else if (r_in_valid && w_advance) begin
            r_st  <= n_st;
            r_ofs <= n_ofs;
        end
    end

    // Header and frame bytes
    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_advance) begin
            r_hdr <= n_hdr;
            r_frm <= n_frm;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid && n_emit) begin
            r_out <= n_res;
        end
    end

    assign o_size.valid        = r_out_valid;
    assign o_size.found        = r_out.found;
    assign o_size.image_format = r_out.fmt;
    assign o_size.image_width  = r_out.width;
    assign o_size.image_height = r_out.height;

endmodule

FILE: hdl/ihss_step.sv
// Next-state and result logic for one byte of the header parser.
module ihss_step #(
    parameter int MIN_FILE_BYTES = 24,
    localparam int OFS_W = $clog2(MIN_FILE_BYTES + 1)
) (
    input  ihss_pkg::t_parse                             i_st,
    input  logic [OFS_W-1:0]                             i_ofs,
    input  logic [ihss_pkg::HDR_LEN-1:0][7:0]            i_hdr,
    input  logic [ihss_pkg::FRM_LEN-1:0][7:0]            i_frm,
    input  logic [7:0]                                   i_byte,
    input  logic                                         i_eof,
    output ihss_pkg::t_parse                             o_st,
    output logic [OFS_W-1:0]                             o_ofs,
    output logic [ihss_pkg::HDR_LEN-1:0][7:0]            o_hdr,
    output logic [ihss_pkg::FRM_LEN-1:0][7:0]            o_frm,
    output logic                                         o_emit,
    output ihss_pkg::t_result                            o_res
);

    localparam logic [OFS_W-1:0] OFS_MAX  = OFS_W'(MIN_FILE_BYTES);
    localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(ihss_pkg::HDR_LEN - 1);

    logic [15:0] w_len;
    logic [15:0] w_skip_dec;
    logic [2:0]  w_frm_idx;
    logic        w_is_sof;
    logic        w_is_gif;
    logic        w_is_png;

    // Place the verdict and close the parse
    function automatic ihss_pkg::t_parse settle(ihss_pkg::t_parse s, logic f,
                                                ihss_pkg::t_fmt fmt,
                                                logic [30:0] w, logic [30:0] h);
        ihss_pkg::t_parse r;
        r                = s;
        r.phase          = ihss_pkg::PH_DONE;
        r.verdict.found  = f;
        r.verdict.fmt    = f ? fmt : ihss_pkg::FMT_NONE;
        r.verdict.width  = f ? w : 31'd0;
        r.verdict.height = f ? h : 31'd0;
        return r;
    endfunction

    assign w_len      = {i_st.len_hi, i_byte};
    assign w_skip_dec = (i_st.skip != 16'd0) ? i_st.skip - 16'd1 : i_st.skip;
    assign w_frm_idx  = i_st.skip[2:0];
    assign w_is_sof   = (i_byte >= ihss_pkg::SOF0 && i_byte <= ihss_pkg::SOF3) ||
                        (i_byte >= ihss_pkg::SOF9 && i_byte <= ihss_pkg::SOF11);

    // Header signatures, looked at with the current byte in place
    assign w_is_gif = o_hdr[0] == "G" && o_hdr[1] == "I" && o_hdr[2] == "F";
    assign w_is_png = o_hdr[0] == ihss_pkg::PNG_LEAD && o_hdr[1] == "P" &&
                      o_hdr[2] == "N" && o_hdr[3] == "G" &&
                      o_hdr[4] == 8'h0D && o_hdr[5] == 8'h0A &&
                      o_hdr[6] == 8'h1A && o_hdr[7] == 8'h0A &&
                      o_hdr[12] == "I" && o_hdr[13] == "H" &&
                      o_hdr[14] == "D" && o_hdr[15] == "R";

    // Header capture of the leading bytes
    always_comb begin
        o_hdr = i_hdr;
        for (int k = 0; k < ihss_pkg::HDR_LEN; k++) begin
            if (i_ofs == OFS_W'(k)) begin
                o_hdr[k] = i_byte;
            end
        end
    end

    // Offset counter, saturating once the minimum size is reached and cleared on the final byte
    assign o_ofs = i_eof ? '0 : ((i_ofs == OFS_MAX) ? i_ofs : i_ofs + OFS_W'(1));

    // Parser phases, result release and end-of-file clear
    always_comb begin
        o_st   = i_st;
        o_frm  = i_frm;
        o_emit = 1'b0;
        o_res  = '0;

        unique case (i_st.phase)
            ihss_pkg::PH_SIG: begin
                if (i_ofs != '0) begin
                    o_st.phase = (i_hdr[0] == ihss_pkg::JPEG_MARK &&
                                  i_byte == ihss_pkg::JPEG_SOI)
                                 ? ihss_pkg::PH_MARK0 : ihss_pkg::PH_HEADER;
                end
            end
            ihss_pkg::PH_HEADER: begin
                if (i_ofs == OFS_LAST) begin
                    if (w_is_gif) begin
                        o_st = settle(i_st, 1'b1, ihss_pkg::FMT_GIF,
                                      {15'd0, o_hdr[7], o_hdr[6]},
                                      {15'd0, o_hdr[9], o_hdr[8]});
                    end else if (w_is_png && !o_hdr[16][7] && !o_hdr[20][7]) begin
                        o_st = settle(i_st, 1'b1, ihss_pkg::FMT_PNG,
                                      {o_hdr[16][6:0], o_hdr[17], o_hdr[18], o_hdr[19]},
                                      {o_hdr[20][6:0], o_hdr[21], o_hdr[22], o_hdr[23]});
                    end else begin
                        o_st = settle(i_st, 1'b0, ihss_pkg::FMT_NONE, 31'd0, 31'd0);
                    end
                end
            end
            ihss_pkg::PH_MARK0: begin
                if (i_byte != ihss_pkg::JPEG_MARK) begin
                    o_st = settle(i_st, 1'b0, ihss_pkg::FMT_NONE, 31'd0, 31'd0);
                end else begin
                    o_st.phase = ihss_pkg::PH_MARK1;
                end
            end
            ihss_pkg::PH_MARK1: begin
                o_st.is_sof = w_is_sof;
                o_st.phase  = ihss_pkg::PH_LEN_HI;
            end
            ihss_pkg::PH_LEN_HI: begin
                o_st.len_hi = i_byte;
                o_st.phase  = ihss_pkg::PH_LEN_LO;
            end
            ihss_pkg::PH_LEN_LO: begin
                if (i_st.is_sof) begin
                    o_st.skip  = 16'd0;
                    o_st.phase = ihss_pkg::PH_FRAME;
                end else if (w_len < 16'd2) begin
                    o_st = settle(i_st, 1'b0, ihss_pkg::FMT_NONE, 31'd0, 31'd0);
                end else if (w_len == 16'd2) begin
                    o_st.phase = ihss_pkg::PH_MARK0;
                end else begin
                    o_st.skip  = w_len - 16'd2;
                    o_st.phase = ihss_pkg::PH_SKIP;
                end
            end
            ihss_pkg::PH_SKIP: begin
                o_st.skip = w_skip_dec;
                if (w_skip_dec == 16'd0) begin
                    o_st.phase = ihss_pkg::PH_MARK0;
                end
            end
            ihss_pkg::PH_FRAME: begin
                // frame bytes 1..4 hold height then width, big-endian
                if (w_frm_idx >= 3'd1 && w_frm_idx <= 3'd4) begin
                    o_frm[2'(w_frm_idx - 3'd1)] = i_byte;
                end
                if (i_st.skip >= 16'd7) begin
                    o_st = settle(i_st, 1'b1, ihss_pkg::FMT_JPEG,
                                  {15'd0, i_frm[2], i_frm[3]},
                                  {15'd0, i_frm[0], i_frm[1]});
                end else begin
                    o_st.skip = i_st.skip + 16'd1;
                end
            end
            default: begin
            end
        endcase

        // Release the verdict once it is settled and the file is long enough
        if (!i_st.sent && o_st.phase == ihss_pkg::PH_DONE &&
            (i_ofs == OFS_MAX || i_ofs + OFS_W'(1) == OFS_MAX)) begin
            o_emit    = 1'b1;
            o_res     = o_st.verdict;
            o_st.sent = 1'b1;
        end

        // Final byte: failure if nothing went out, then start afresh
        if (i_eof) begin
            if (!o_st.sent) begin
                o_emit = 1'b1;
                o_res  = '0;
            end
            o_st = ihss_pkg::PARSE_CLEAR;
        end
    end

endmodule

FILE: hdl/ihss_checker.sv
// Port-level checks of the image header size sniffer, with their bind.
`include "image_header_size_sniffer_core_macros.svh"

module ihss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [1:0]  i_format,
    input logic [30:0] i_width,
    input logic [30:0] i_height
);

    // A stalled result holds
    `IHSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_found, i_format, i_width, i_height}))

    // A failure carries no format and no size
    `IHSS_ASSERT(a_fail_zero, i_clk, i_rst_n, i_out_valid && !i_found, i_format == ihss_pkg::FMT_NONE && i_width == 31'd0 && i_height == 31'd0)

    // A success always names a format
    `IHSS_ASSERT(a_found_fmt, i_clk, i_rst_n, i_out_valid && i_found, i_format != ihss_pkg::FMT_NONE)

    // GIF and JPEG sizes are 16-bit fields
    `IHSS_ASSERT(a_small_size, i_clk, i_rst_n, i_out_valid && (i_format == ihss_pkg::FMT_GIF || i_format == ihss_pkg::FMT_JPEG), i_width[30:16] == 15'd0 && i_height[30:16] == 15'd0)

    // Reset empties the result register
    `IHSS_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind image_header_size_sniffer_core ihss_checker u_ihss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_size.valid),
    .i_out_ready (o_size.ready),
    .i_found     (o_size.found),
    .i_format    (o_size.image_format),
    .i_width     (o_size.image_width),
    .i_height    (o_size.image_height)
);
